// ----- design/clnr_pkg.sv -----
// ----------------------------------------------------------------------------
// clnr_pkg
// Shared constants, codes and control types of the periodic cell-list
// nearest-neighbour search block.
// ----------------------------------------------------------------------------
package clnr_pkg;

    localparam int MAX_POINTS_DEF  = 65536;
    localparam int GRID_MAX_DEF    = 32;
    localparam int COORD_BITS_DEF  = 24;

    localparam int CFG_BITS        = 6;
    localparam int RADIUS_BITS     = 24;
    localparam int OPCODE_BITS     = 2;
    localparam int STATUS_BITS     = 3;
    localparam int INDEX_BITS      = 16;
    localparam int DIST_BITS       = 48;
    localparam int LIMIT_BITS      = 2 * RADIUS_BITS + 2;
    localparam int JR_BITS         = RADIUS_BITS + 2 + CFG_BITS;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(32);

    localparam logic [OPCODE_BITS-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_INSERT = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_QUERY  = 2'd2;
    localparam logic [OPCODE_BITS-1:0] OP_NOP    = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_CLEARED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_MATCH    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NO_MATCH = 3'd4;

    typedef struct packed {
        logic start;
        logic push;
    } dist_ctrl_t;

    typedef struct packed {
        logic busy;
        logic found;
    } dist_stat_t;

endpackage

// ----- design/cell_list_nearest_in_radius.sv -----
// ----------------------------------------------------------------------------
// cell_list_nearest_in_radius
// Periodic-box neighbour finder: points are linked into per-cell lists held
// in a cell head memory and a point memory; queries walk the wrapped cell
// window around the query point and keep the nearest point within reach.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid / in_stall       opcode, x/y/z_coord, radius
//  out      output     out_valid / out_stall     status, point_index, dist_sq
//  cfg      input      cfg_write                 cfg_data (cells_per_side)
//
// After reset the cell head memory is swept, one entry a cycle, through all
// GRID_MAX^3 entries (32768 by default) while in_stall stays high.
// A clear runs the same sweep and then reports; an insert reads the cell
// head and then writes the point and the new head. A query reads the head
// of each cell of the window and then each stored point met, as both memories
// have a registered read, then waits while the distance pipeline empties.
// The next transaction is taken while a result still waits in the output
// register; a stalled output holds the block at the end of its next item.
// ----------------------------------------------------------------------------
module cell_list_nearest_in_radius #(
    parameter int MAX_POINTS = clnr_pkg::MAX_POINTS_DEF,
    parameter int GRID_MAX   = clnr_pkg::GRID_MAX_DEF,
    parameter int COORD_BITS = clnr_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [clnr_pkg::CFG_BITS-1:0]      cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [clnr_pkg::OPCODE_BITS-1:0]   opcode,
    input  logic [COORD_BITS-1:0]              x_coord,
    input  logic [COORD_BITS-1:0]              y_coord,
    input  logic [COORD_BITS-1:0]              z_coord,
    input  logic [clnr_pkg::RADIUS_BITS-1:0]   radius,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [clnr_pkg::STATUS_BITS-1:0]   status,
    output logic [clnr_pkg::INDEX_BITS-1:0]    point_index,
    output logic [clnr_pkg::DIST_BITS-1:0]     dist_sq
);
    import clnr_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int LNK_W  = $clog2(MAX_POINTS + 1);
    localparam int HDEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int HA_W   = $clog2(HDEPTH);
    localparam int DW     = 2 * COORD_BITS;
    localparam int PW     = 3 * COORD_BITS + LNK_W;
    localparam int CPW    = COORD_BITS + CFG_BITS;

    localparam logic [3:0] S_SWEEP   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CALC    = 4'd2;
    localparam logic [3:0] S_SETUP   = 4'd3;
    localparam logic [3:0] S_INS_RD  = 4'd4;
    localparam logic [3:0] S_INS_WR  = 4'd5;
    localparam logic [3:0] S_Q_CELL  = 4'd6;
    localparam logic [3:0] S_Q_HEAD  = 4'd7;
    localparam logic [3:0] S_Q_PT    = 4'd8;
    localparam logic [3:0] S_Q_DRAIN = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    // control state
    logic [3:0]             state_reg, state_next;
    logic [CFG_BITS-1:0]    cfg_reg;
    logic [LNK_W-1:0]       count_reg, count_next;
    logic [HA_W-1:0]        sweep_reg, sweep_next;
    logic                   clr_report_reg, clr_report_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    logic [OPCODE_BITS-1:0] op_reg, op_next;
    logic [COORD_BITS-1:0]  qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next;
    logic [RADIUS_BITS-1:0] rad_reg, rad_next;
    logic [CFG_BITS-1:0]    n_reg, n_next;
    logic [CFG_BITS-1:0]    ctrx_reg, ctrx_next, ctry_reg, ctry_next, ctrz_reg, ctrz_next;
    logic [JR_BITS-1:0]     prod_reg, prod_next;
    logic [2*RADIUS_BITS-1:0] r2_reg, r2_next;
    logic [LIMIT_BITS-1:0]  limit_reg, limit_next;
    logic [CFG_BITS-1:0]    cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [CFG_BITS-1:0]    lox_reg, lox_next, loy_reg, loy_next, loz_reg, loz_next;
    logic [CFG_BITS-1:0]    span_reg, span_next;
    logic [CFG_BITS-1:0]    ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;
    logic [LNK_W-1:0]       link_reg, link_next;
    logic [STATUS_BITS-1:0] res_st_reg, res_st_next;
    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;
    logic [DW-1:0]          res_d_reg, res_d_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [INDEX_BITS-1:0]  index_reg, index_next;
    logic [DIST_BITS-1:0]   dist_reg, dist_next;

    // memory and distance unit connections
    logic                   head_we, head_re;
    logic [HA_W-1:0]        head_waddr, cell_addr;
    logic [LNK_W-1:0]       head_wdata, head_rdata;
    logic                   pt_we, pt_re;
    logic [IDX_W-1:0]       pt_waddr, pt_raddr;
    logic [PW-1:0]          pt_wdata, pt_rdata;
    logic [COORD_BITS-1:0]  pt_x, pt_y, pt_z;
    logic [LNK_W-1:0]       pt_link;
    dist_ctrl_t             dctrl;
    dist_stat_t             dstat;
    logic [IDX_W-1:0]       best_idx;
    logic [DW-1:0]          best_dist;

    // combinational helpers
    logic [CFG_BITS-1:0]    n_eff;
    logic [CPW-1:0]         mul_x, mul_y, mul_z;
    logic [RADIUS_BITS+1:0] rad3;
    logic [JR_BITS-1:0]     jr;
    logic                   full_win;
    logic [CFG_BITS-1:0]    jr_s;
    logic [CFG_BITS-1:0]    lo_x, lo_y, lo_z;
    logic                   adv_done;
    logic [CFG_BITS-1:0]    adv_ca, adv_cb, adv_cc, adv_cx, adv_cy, adv_cz;
    logic                   out_take;

    function automatic logic [CFG_BITS-1:0] wrap_inc(input logic [CFG_BITS-1:0] v,
                                                      input logic [CFG_BITS-1:0] n);
        logic [CFG_BITS:0] t;
        t = {1'b0, v} + 1'b1;
        wrap_inc = (t == {1'b0, n}) ? '0 : t[CFG_BITS-1:0];
    endfunction

    function automatic logic [CFG_BITS-1:0] win_lo(input logic [CFG_BITS-1:0] c,
                                                    input logic [CFG_BITS-1:0] n,
                                                    input logic [CFG_BITS-1:0] j);
        logic [CFG_BITS:0] t;
        t = {1'b0, c} + {1'b0, n} - {1'b0, j};
        win_lo = (t >= {1'b0, n}) ? CFG_BITS'(t - {1'b0, n}) : t[CFG_BITS-1:0];
    endfunction

    clnr_head_ram #(
        .DEPTH  (HDEPTH),
        .ADDR_W (HA_W),
        .DATA_W (LNK_W)
    ) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (cell_addr),
        .rdata (head_rdata)
    );

    clnr_point_ram #(
        .DEPTH  (MAX_POINTS),
        .ADDR_W (IDX_W),
        .DATA_W (PW)
    ) u_point (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    clnr_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dctrl),
        .px        (pt_x),
        .py        (pt_y),
        .pz        (pt_z),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .qz        (qz_reg),
        .pidx      (IDX_W'(link_reg - 1'b1)),
        .limit     (limit_reg),
        .stat      (dstat),
        .best_idx  (best_idx),
        .best_dist (best_dist)
    );

    assign {pt_x, pt_y, pt_z, pt_link} = pt_rdata;
    assign cell_addr = HA_W'(cx_reg) * HA_W'(GRID_MAX * GRID_MAX)
                     + HA_W'(cy_reg) * HA_W'(GRID_MAX) + HA_W'(cz_reg);

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign point_index = index_reg;
    assign dist_sq     = dist_reg;
    assign out_take    = !out_valid_reg || !out_stall;

    always_comb
    begin
        // Out-of-range grid sizes are clamped to one and to the grid maximum.
        if (cfg_reg == '0)
        begin
            n_eff = CFG_BITS'(1);
        end
        else if (32'(cfg_reg) > GRID_MAX)
        begin
            n_eff = CFG_BITS'(GRID_MAX);
        end
        else
        begin
            n_eff = cfg_reg;
        end

        mul_x = CPW'(qx_reg) * CPW'(n_reg);
        mul_y = CPW'(qy_reg) * CPW'(n_reg);
        mul_z = CPW'(qz_reg) * CPW'(n_reg);
        rad3  = (RADIUS_BITS+2)'(rad_reg) + ((RADIUS_BITS+2)'(rad_reg) << 1);

        jr = (prod_reg >> (COORD_BITS + 1)) + 1'b1;
        full_win = (((JR_BITS+2)'(jr) << 1) + 1'b1) >= (JR_BITS+2)'(n_reg);
        jr_s = jr[CFG_BITS-1:0];
        lo_x = win_lo(ctrx_reg, n_reg, jr_s);
        lo_y = win_lo(ctry_reg, n_reg, jr_s);
        lo_z = win_lo(ctrz_reg, n_reg, jr_s);

        // Step to the next cell of the window: x fastest, then y, then z.
        adv_done = 1'b0;
        adv_ca = ca_reg;
        adv_cb = cb_reg;
        adv_cc = cc_reg;
        adv_cx = cx_reg;
        adv_cy = cy_reg;
        adv_cz = cz_reg;
        if (ca_reg != span_reg - 1'b1)
        begin
            adv_ca = ca_reg + 1'b1;
            adv_cx = wrap_inc(cx_reg, n_reg);
        end
        else
        begin
            adv_ca = '0;
            adv_cx = lox_reg;
            if (cb_reg != span_reg - 1'b1)
            begin
                adv_cb = cb_reg + 1'b1;
                adv_cy = wrap_inc(cy_reg, n_reg);
            end
            else
            begin
                adv_cb = '0;
                adv_cy = loy_reg;
                if (cc_reg != span_reg - 1'b1)
                begin
                    adv_cc = cc_reg + 1'b1;
                    adv_cz = wrap_inc(cz_reg, n_reg);
                end
                else
                begin
                    adv_done = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sweep_next = sweep_reg;
        clr_report_next = clr_report_reg;
        out_valid_next = out_valid_reg;
        op_next = op_reg;
        qx_next = qx_reg;
        qy_next = qy_reg;
        qz_next = qz_reg;
        rad_next = rad_reg;
        n_next = n_reg;
        ctrx_next = ctrx_reg;
        ctry_next = ctry_reg;
        ctrz_next = ctrz_reg;
        prod_next = prod_reg;
        r2_next = r2_reg;
        limit_next = limit_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        lox_next = lox_reg;
        loy_next = loy_reg;
        loz_next = loz_reg;
        span_next = span_reg;
        ca_next = ca_reg;
        cb_next = cb_reg;
        cc_next = cc_reg;
        link_next = link_reg;
        res_st_next = res_st_reg;
        res_idx_next = res_idx_reg;
        res_d_next = res_d_reg;
        status_next = status_reg;
        index_next = index_reg;
        dist_next = dist_reg;

        head_we = 1'b0;
        head_waddr = cell_addr;
        head_wdata = LNK_W'(count_reg + 1'b1);
        head_re = 1'b0;
        pt_we = 1'b0;
        pt_waddr = count_reg[IDX_W-1:0];
        pt_wdata = {qx_reg, qy_reg, qz_reg, head_rdata};
        pt_re = 1'b0;
        pt_raddr = IDX_W'(pt_link - 1'b1);
        dctrl.start = 1'b0;
        dctrl.push = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP:
            begin
                head_we = 1'b1;
                head_waddr = sweep_reg;
                head_wdata = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == HA_W'(HDEPTH - 1))
                begin
                    sweep_next = '0;
                    count_next = '0;
                    res_st_next = ST_CLEARED;
                    res_idx_next = '0;
                    res_d_next = '0;
                    state_next = clr_report_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = opcode;
                    qx_next = x_coord;
                    qy_next = y_coord;
                    qz_next = z_coord;
                    rad_next = radius;
                    n_next = n_eff;
                    res_idx_next = '0;
                    res_d_next = '0;
                    case (opcode)
                        OP_CLEAR:
                        begin
                            clr_report_next = 1'b1;
                            sweep_next = '0;
                            state_next = S_SWEEP;
                        end
                        OP_INSERT:
                        begin
                            if (32'(count_reg) == MAX_POINTS)
                            begin
                                res_st_next = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CALC;
                            end
                        end
                        OP_QUERY:
                        begin
                            state_next = S_CALC;
                        end
                        default:
                        begin
                            res_st_next = ST_NO_MATCH;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CALC:
            begin
                ctrx_next = mul_x[COORD_BITS +: CFG_BITS];
                ctry_next = mul_y[COORD_BITS +: CFG_BITS];
                ctrz_next = mul_z[COORD_BITS +: CFG_BITS];
                prod_next = JR_BITS'(rad3) * JR_BITS'(n_reg);
                r2_next = (2*RADIUS_BITS)'(rad_reg) * (2*RADIUS_BITS)'(rad_reg);
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                // Reach test: d^2 <= 2 r^2 + floor(r^2 / 4), i.e. d <= 1.5 r.
                limit_next = (LIMIT_BITS'(r2_reg) << 1) + LIMIT_BITS'(r2_reg >> 2);
                ca_next = '0;
                cb_next = '0;
                cc_next = '0;
                if (op_reg == OP_INSERT)
                begin
                    cx_next = ctrx_reg;
                    cy_next = ctry_reg;
                    cz_next = ctrz_reg;
                    state_next = S_INS_RD;
                end
                else
                begin
                    dctrl.start = 1'b1;
                    if (full_win)
                    begin
                        span_next = n_reg;
                        lox_next = '0;
                        loy_next = '0;
                        loz_next = '0;
                        cx_next = '0;
                        cy_next = '0;
                        cz_next = '0;
                    end
                    else
                    begin
                        span_next = CFG_BITS'({jr_s, 1'b1});
                        lox_next = lo_x;
                        loy_next = lo_y;
                        loz_next = lo_z;
                        cx_next = lo_x;
                        cy_next = lo_y;
                        cz_next = lo_z;
                    end
                    state_next = S_Q_CELL;
                end
            end
            S_INS_RD:
            begin
                head_re = 1'b1;
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                // The old head becomes the new point's link.
                pt_we = 1'b1;
                head_we = 1'b1;
                count_next = count_reg + 1'b1;
                res_st_next = ST_INSERTED;
                res_idx_next = count_reg[IDX_W-1:0];
                state_next = S_DONE;
            end
            S_Q_CELL:
            begin
                head_re = 1'b1;
                state_next = S_Q_HEAD;
            end
            S_Q_HEAD:
            begin
                if (head_rdata != '0)
                begin
                    pt_re = 1'b1;
                    pt_raddr = IDX_W'(head_rdata - 1'b1);
                    link_next = head_rdata;
                    state_next = S_Q_PT;
                end
                else
                begin
                    ca_next = adv_ca;
                    cb_next = adv_cb;
                    cc_next = adv_cc;
                    cx_next = adv_cx;
                    cy_next = adv_cy;
                    cz_next = adv_cz;
                    state_next = adv_done ? S_Q_DRAIN : S_Q_CELL;
                end
            end
            S_Q_PT:
            begin
                dctrl.push = 1'b1;
                // Links only run towards older points; anything else ends the list.
                if (pt_link != '0 && pt_link < link_reg)
                begin
                    pt_re = 1'b1;
                    link_next = pt_link;
                end
                else
                begin
                    ca_next = adv_ca;
                    cb_next = adv_cb;
                    cc_next = adv_cc;
                    cx_next = adv_cx;
                    cy_next = adv_cy;
                    cz_next = adv_cz;
                    state_next = adv_done ? S_Q_DRAIN : S_Q_CELL;
                end
            end
            S_Q_DRAIN:
            begin
                if (!dstat.busy)
                begin
                    res_st_next = dstat.found ? ST_MATCH : ST_NO_MATCH;
                    res_idx_next = dstat.found ? best_idx : '0;
                    res_d_next = dstat.found ? best_dist : '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b1;
                    status_next = res_st_reg;
                    index_next = INDEX_BITS'(res_idx_reg);
                    dist_next = DIST_BITS'(res_d_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            cfg_reg <= CFG_RESET;
            count_reg <= '0;
            sweep_reg <= '0;
            clr_report_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                cfg_reg <= cfg_data;
            end
            count_reg <= count_next;
            sweep_reg <= sweep_next;
            clr_report_reg <= (state_reg == S_SWEEP && state_next != S_SWEEP) ?
                              1'b0 : clr_report_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        qz_reg <= qz_next;
        rad_reg <= rad_next;
        n_reg <= n_next;
        ctrx_reg <= ctrx_next;
        ctry_reg <= ctry_next;
        ctrz_reg <= ctrz_next;
        prod_reg <= prod_next;
        r2_reg <= r2_next;
        limit_reg <= limit_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        lox_reg <= lox_next;
        loy_reg <= loy_next;
        loz_reg <= loz_next;
        span_reg <= span_next;
        ca_reg <= ca_next;
        cb_reg <= cb_next;
        cc_reg <= cc_next;
        link_reg <= link_next;
        res_st_reg <= res_st_next;
        res_idx_reg <= res_idx_next;
        res_d_reg <= res_d_next;
        status_reg <= status_next;
        index_reg <= index_next;
        dist_reg <= dist_next;
    end

endmodule

// ----- design/clnr_head_ram.sv -----
// ----------------------------------------------------------------------------
// clnr_head_ram
// Cell head table: one entry per grid cell holding the most recent point
// index plus one, or zero for an empty cell. One write and one registered
// read port.
// ----------------------------------------------------------------------------
module clnr_head_ram #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15,
    parameter int DATA_W = 17
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    import clnr_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/clnr_point_ram.sv -----
// ----------------------------------------------------------------------------
// clnr_point_ram
// Point store: per point index the three coordinates and the link to the
// next point of the same cell. One write and one registered read port.
// ----------------------------------------------------------------------------
module clnr_point_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 89
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    import clnr_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/clnr_dist_unit.sv -----
// ----------------------------------------------------------------------------
// clnr_dist_unit
// Minimum-image squared distance pipeline with a running best match.
// Stage one folds the axis differences, stage two squares them, and the
// final step sums, checks the reach limit and updates the best candidate.
// ----------------------------------------------------------------------------
module clnr_dist_unit #(
    parameter int COORD_BITS = 24,
    parameter int IDX_W      = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  clnr_pkg::dist_ctrl_t               ctrl,
    input  logic [COORD_BITS-1:0]              px,
    input  logic [COORD_BITS-1:0]              py,
    input  logic [COORD_BITS-1:0]              pz,
    input  logic [COORD_BITS-1:0]              qx,
    input  logic [COORD_BITS-1:0]              qy,
    input  logic [COORD_BITS-1:0]              qz,
    input  logic [IDX_W-1:0]                   pidx,
    input  logic [clnr_pkg::LIMIT_BITS-1:0]    limit,
    output clnr_pkg::dist_stat_t               stat,
    output logic [IDX_W-1:0]                   best_idx,
    output logic [2*COORD_BITS-1:0]            best_dist
);
    import clnr_pkg::*;

    localparam int DW   = 2 * COORD_BITS;
    localparam int CMPW = (DW > LIMIT_BITS) ? DW : LIMIT_BITS;
    localparam logic [COORD_BITS-1:0] HALF = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                  v1_reg, v1_next;
    logic                  v2_reg, v2_next;
    logic                  found_reg, found_next;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic [IDX_W-1:0]      i1_reg, i2_reg;
    logic [DW-1:0]         sx_reg, sy_reg, sz_reg;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [DW-1:0]         best_dist_reg, best_dist_next;
    logic [COORD_BITS-1:0] rx, ry, rz;
    logic [DW-1:0]         sum;
    logic                  better;

    function automatic logic [COORD_BITS-1:0] fold(input logic [COORD_BITS-1:0] d);
        fold = (d > HALF) ? (~d + 1'b1) : d;
    endfunction

    always_comb
    begin
        rx = px - qx;
        ry = py - qy;
        rz = pz - qz;
        sum = sx_reg + sy_reg + sz_reg;
        // A later point replaces the best only when it is strictly nearer.
        better = (CMPW'(sum) <= CMPW'(limit)) && (!found_reg || sum < best_dist_reg);

        v1_next = ctrl.push;
        v2_next = v1_reg;
        found_next = found_reg;
        best_idx_next = best_idx_reg;
        best_dist_next = best_dist_reg;
        if (ctrl.start)
        begin
            found_next = 1'b0;
            best_idx_next = '0;
            best_dist_next = '0;
        end
        else if (v2_reg && better)
        begin
            found_next = 1'b1;
            best_idx_next = i2_reg;
            best_dist_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= fold(rx);
        dy_reg <= fold(ry);
        dz_reg <= fold(rz);
        i1_reg <= pidx;
        sx_reg <= DW'(dx_reg) * DW'(dx_reg);
        sy_reg <= DW'(dy_reg) * DW'(dy_reg);
        sz_reg <= DW'(dz_reg) * DW'(dz_reg);
        i2_reg <= i1_reg;
        best_idx_reg <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    assign stat.busy  = v1_reg | v2_reg;
    assign stat.found = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_dist  = best_dist_reg;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic cell-list nearest-neighbour block.
// A scoreboard keeps its own copy of the cell lists and computes the status,
// index and squared distance of every transaction sent. Stimulus runs through
// several grid sizes, random idling on both sides, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import clnr_pkg::*;

    localparam int NPTS    = MAX_POINTS_DEF;
    localparam int GMAX    = GRID_MAX_DEF;
    localparam int CBITS   = COORD_BITS_DEF;
    localparam int WDOG    = 300000;
    localparam logic [23:0] CMAX = 24'hFFFFFF;

    typedef struct {
        logic [STATUS_BITS-1:0] st;
        logic [INDEX_BITS-1:0]  idx;
        logic [DIST_BITS-1:0]   d2;
    } search_result_t;

    class neighbour_scoreboard;
        int unsigned head[GMAX*GMAX*GMAX];
        int unsigned link[NPTS];
        logic [23:0] px[NPTS];
        logic [23:0] py[NPTS];
        logic [23:0] pz[NPTS];
        int unsigned count;
        int unsigned grid;
        int unsigned errors;
        search_result_t pending[$];

        function void init();
            foreach (head[i]) head[i] = 0;
            count = 0;
            grid = 32;
            errors = 0;
        endfunction

        function longint unsigned cell_of(logic [23:0] c);
            return (longint'(c) * grid) >> CBITS;
        endfunction

        function longint unsigned axis_sq(logic [23:0] a, logic [23:0] b);
            longint unsigned d;
            d = (longint'(a) - longint'(b)) & ((64'd1 << CBITS) - 64'd1);
            if (d > (64'd1 << (CBITS-1))) d = (64'd1 << CBITS) - d;
            return d * d;
        endfunction

        function int unsigned cell_addr(longint unsigned cx, longint unsigned cy,
                                        longint unsigned cz);
            return int'(((cx * GMAX + cy) * GMAX + cz) % (GMAX*GMAX*GMAX));
        endfunction

        function void set_grid(logic [CFG_BITS-1:0] v);
            grid = (v == 0) ? 1 : ((v > GMAX) ? GMAX : v);
        endfunction

        // Works out the result of one accepted transaction and queues it.
        function void note_input(logic [1:0] op, logic [23:0] x, logic [23:0] y,
                                 logic [23:0] z, logic [23:0] r);
            search_result_t res;
            longint unsigned jr, span, r2, lim, d2, best_d;
            longint unsigned lo[3], ctr[3], cx, cy, cz;
            int unsigned a, lk, p, best_i;
            bit found;
            res.st = ST_NO_MATCH;
            res.idx = 0;
            res.d2 = 0;
            if (op == OP_CLEAR) begin
                foreach (head[i]) head[i] = 0;
                count = 0;
                res.st = ST_CLEARED;
            end else if (op == OP_INSERT) begin
                if (count >= NPTS) begin
                    res.st = ST_FULL;
                end else begin
                    px[count] = x;
                    py[count] = y;
                    pz[count] = z;
                    a = cell_addr(cell_of(x), cell_of(y), cell_of(z));
                    link[count] = head[a];
                    head[a] = count + 1;
                    res.st = ST_INSERTED;
                    res.idx = INDEX_BITS'(count);
                    count++;
                end
            end else if (op == OP_QUERY) begin
                jr = ((3 * longint'(r) * grid) >> (CBITS + 1)) + 1;
                r2 = longint'(r) * r;
                lim = 2 * r2 + (r2 >> 2);
                found = 0;
                best_i = 0;
                best_d = 0;
                ctr[0] = cell_of(x);
                ctr[1] = cell_of(y);
                ctr[2] = cell_of(z);
                if (2 * jr + 1 >= grid) begin
                    span = grid;
                    lo = '{0, 0, 0};
                end else begin
                    span = 2 * jr + 1;
                    for (int k = 0; k < 3; k++) lo[k] = (ctr[k] + grid - jr) % grid;
                end
                // z outermost, then y, then x; each cell from its head.
                for (int c = 0; c < span; c++) begin
                    cz = (lo[2] + c) % grid;
                    for (int b = 0; b < span; b++) begin
                        cy = (lo[1] + b) % grid;
                        for (int e = 0; e < span; e++) begin
                            cx = (lo[0] + e) % grid;
                            lk = head[cell_addr(cx, cy, cz)];
                            while (lk != 0) begin
                                p = lk - 1;
                                d2 = axis_sq(px[p], x) + axis_sq(py[p], y)
                                   + axis_sq(pz[p], z);
                                if (d2 <= lim && (!found || d2 < best_d)) begin
                                    found = 1;
                                    best_i = p;
                                    best_d = d2;
                                end
                                if (link[p] >= lk) break;
                                lk = link[p];
                            end
                        end
                    end
                end
                if (found) begin
                    res.st = ST_MATCH;
                    res.idx = INDEX_BITS'(best_i);
                    res.d2 = DIST_BITS'(best_d);
                end
            end
            pending = {pending, res};
        endfunction

        function void check_result(logic [STATUS_BITS-1:0] st,
                                   logic [INDEX_BITS-1:0] idx,
                                   logic [DIST_BITS-1:0] d2);
            search_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status %0d index %0d dist %0d",
                         $realtime, st, idx, d2);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.st) begin
                $display("%0t: status expected %0d actual %0d", $realtime, e.st, st);
                errors++;
            end
            if (idx !== e.idx) begin
                $display("%0t: point_index expected %0d actual %0d",
                         $realtime, e.idx, idx);
                errors++;
            end
            if (d2 !== e.d2) begin
                $display("%0t: dist_sq expected %0d actual %0d", $realtime, e.d2, d2);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   cfg_write = 0;
    logic [CFG_BITS-1:0]    cfg_data = '0;
    logic                   in_valid = 0;
    logic                   in_stall;
    logic [1:0]             opcode = OP_CLEAR;
    logic [23:0]            x_coord = '0;
    logic [23:0]            y_coord = '0;
    logic [23:0]            z_coord = '0;
    logic [23:0]            radius = '0;
    logic                   out_valid;
    logic                   out_stall = 1;
    logic [STATUS_BITS-1:0] status;
    logic [INDEX_BITS-1:0]  point_index;
    logic [DIST_BITS-1:0]   dist_sq;

    neighbour_scoreboard sb;
    bit  no_idle = 0;
    bit  hold_req = 0;
    int  quiet_cycles = 0;

    cell_list_nearest_in_radius i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .x_coord(x_coord), .y_coord(y_coord),
        .z_coord(z_coord), .radius(radius),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .point_index(point_index), .dist_sq(dist_sq)
    );

    always #10 clk = ~clk;

    function int idle_len();
        int k;
        k = $urandom_range(0, 99);
        if (no_idle || k < 55) return 0;
        if (k < 90) return $urandom_range(1, 3);
        if (k < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function logic [23:0] rand24();
        return 24'($urandom);
    endfunction

    // Receiver: random stalls, or one long hold-off when requested.
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall = 1;
                repeat (600) @(negedge clk);
                hold_req = 0;
            end
            n = idle_len();
            out_stall = (n != 0);
            repeat (n > 1 ? n - 1 : 0) @(negedge clk);
            if (n != 0) begin
                @(negedge clk);
                out_stall = 0;
            end
        end
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall) sb.check_result(status, point_index, dist_sq);
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [23:0] x, logic [23:0] y,
                             logic [23:0] z, logic [23:0] r);
        int gap;
        @(negedge clk);
        opcode = op;
        x_coord = x;
        y_coord = y;
        z_coord = z;
        radius = r;
        in_valid = 1;
        do @(posedge clk); while (in_stall);
        sb.note_input(op, x, y, z, r);
        gap = idle_len();
        if (gap != 0) begin
            @(negedge clk);
            in_valid = 0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_grid(logic [CFG_BITS-1:0] v);
        drain();
        @(negedge clk);
        cfg_write = 1;
        cfg_data = v;
        @(negedge clk);
        cfg_write = 0;
        sb.set_grid(v);
    endtask

    // A coordinate near a stored point.
    function logic [23:0] near_coord(logic [23:0] c, logic [23:0] spread);
        return 24'(c + $urandom_range(0, spread) - (spread >> 1));
    endfunction

    task automatic random_item();
        int k, p;
        logic [23:0] r, sp;
        k = $urandom_range(0, 99);
        // Keep the window small on fine grids so that queries stay short.
        if (sb.grid <= 4 || $urandom_range(0, 9) == 0 && sb.grid <= 8)
            r = rand24();
        else
            r = 24'($urandom_range(0, (1 << 24) / sb.grid / 2));
        sp = 24'((1 << 24) / sb.grid);
        if (k < 45) begin
            send_item(OP_INSERT, rand24(), rand24(), rand24(), rand24());
        end else if (k < 97 && sb.count != 0) begin
            p = $urandom_range(0, sb.count - 1);
            if ($urandom_range(0, 2) == 0)
                send_item(OP_QUERY, rand24(), rand24(), rand24(), r);
            else
                send_item(OP_QUERY, near_coord(sb.px[p], sp), near_coord(sb.py[p], sp),
                          near_coord(sb.pz[p], sp), r);
        end else begin
            send_item(OP_NOP, rand24(), rand24(), rand24(), rand24());
        end
    endtask

    initial begin
        int grids[10] = '{1, 0, 2, 3, 5, 8, 17, 32, 45, 63};
        sb = new();
        sb.init();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed part at the reset grid.
        send_item(OP_QUERY, 24'h0, 24'h0, 24'h0, 24'h100);
        send_item(OP_INSERT, 24'h0, 24'h0, 24'h0, 24'h0);
        send_item(OP_INSERT, CMAX, CMAX, CMAX, CMAX);
        send_item(OP_INSERT, 24'h800000, 24'h800000, 24'h800000, 24'h0);
        send_item(OP_INSERT, 24'h800000, 24'h800000, 24'h800000, 24'h0);
        send_item(OP_QUERY, CMAX, CMAX, CMAX, 24'h0);
        send_item(OP_QUERY, 24'h000001, 24'h000001, 24'h000001, 24'h10);
        send_item(OP_QUERY, 24'h800000, 24'h800000, 24'h800000, 24'h000001);
        send_item(OP_QUERY, 24'h400000, 24'h400000, 24'h400000, 24'h400000);
        send_item(OP_QUERY, 24'h7FFFFE, 24'h800002, 24'h800000, 24'h000002);
        send_item(OP_QUERY, 24'h400000, 24'hC00000, 24'h000000, CMAX);
        send_item(OP_NOP, CMAX, CMAX, CMAX, CMAX);
        send_item(OP_CLEAR, 24'h0, 24'h0, 24'h0, 24'h0);
        send_item(OP_QUERY, 24'h0, 24'h0, 24'h0, CMAX);
        send_item(OP_INSERT, 24'h123456, 24'hABCDEF, 24'h555555, 24'h0);

        // Grid sweep; the stored lists are kept across grid changes.
        foreach (grids[g]) begin
            write_grid(CFG_BITS'(grids[g]));
            no_idle = (g == 3);
            if (g == 5) hold_req = 1;
            repeat (120) random_item();
            if (g == 6) send_item(OP_CLEAR, 24'h0, 24'h0, 24'h0, 24'h0);
        end
        no_idle = 0;

        // Start again from an empty table at the reset grid.
        write_grid(CFG_RESET);
        send_item(OP_CLEAR, 24'h0, 24'h0, 24'h0, 24'h0);
        repeat (20) random_item();

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
